@@ rtl/itp_pkg.sv @@
// shared types, character codes and helpers for the infix to postfix converter
`timescale 1ns / 1ps
package itp_pkg;

    // character codes with a role in the expression
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_ADD   = 8'h2B;
    localparam logic [7:0] CH_SUB   = 8'h2D;
    localparam logic [7:0] CH_DIV   = 8'h2F;

    // input item
    typedef struct packed {
        logic [7:0] symbol;
        logic       last;
    } t_in;

    // result item
    typedef struct packed {
        logic [7:0] symbol_res;
        logic       last_res;
        logic       overflow;
    } t_out;

    // character class decided by the front end
    typedef enum logic [1:0] {
        K_OTHER = 2'b00,
        K_OPEN  = 2'b01,
        K_CLOSE = 2'b10,
        K_OP    = 2'b11
    } t_kind;

    // classified item carried by the queue
    typedef struct packed {
        t_kind      kind;
        logic [7:0] symbol;
        logic       last;
    } t_cmd;

    // queue status seen by the back end and the top level
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    // operator weight: 2 for multiply and divide, 1 for add and subtract
    function automatic logic [1:0] weight_of(input logic [7:0] c);
        logic [1:0] w;
        if (c == CH_MUL || c == CH_DIV) begin
            w = 2'd2;
        end else if (c == CH_ADD || c == CH_SUB) begin
            w = 2'd1;
        end else begin
            w = 2'd0;
        end
        return w;
    endfunction

endpackage

@@ rtl/itp_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps
module itp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/itp_front.sv @@
// front end: accepts input items, classifies them and queues them for the back end
`timescale 1ns / 1ps
module itp_front import itp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in       i_in_data,
    output logic      o_in_stall,
    input  logic      i_deq,
    output t_cmd      o_cmd,
    output t_q_status o_status
);

    localparam int QD = 4;

    t_cmd       r_q [QD];
    logic [1:0] r_wptr, n_wptr;
    logic [1:0] r_rptr, n_rptr;
    logic [2:0] r_cnt, n_cnt;
    t_cmd       w_cmd;
    logic       w_enq;

    // classify the incoming character
    always_comb begin
        w_cmd.symbol = i_in_data.symbol;
        w_cmd.last   = i_in_data.last;
        if (i_in_data.symbol == CH_OPEN) begin
            w_cmd.kind = K_OPEN;
        end else if (i_in_data.symbol == CH_CLOSE) begin
            w_cmd.kind = K_CLOSE;
        end else if (weight_of(i_in_data.symbol) != 2'd0) begin
            w_cmd.kind = K_OP;
        end else begin
            w_cmd.kind = K_OTHER;
        end
    end

    assign o_status.full  = (r_cnt == 3'(QD));
    assign o_status.empty = (r_cnt == 3'd0);
    assign o_in_stall     = o_status.full;
    assign w_enq          = i_in_valid && !o_status.full;
    assign o_cmd          = r_q[r_rptr];

    // pointer and fill count update
    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (w_enq) begin
            n_wptr = r_wptr + 2'd1;
        end
        if (i_deq) begin
            n_rptr = r_rptr + 2'd1;
        end
        if (w_enq && !i_deq) begin
            n_cnt = r_cnt + 3'd1;
        end else if (!w_enq && i_deq) begin
            n_cnt = r_cnt - 3'd1;
        end
    end

    // queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 2'd0;
            r_rptr <= 2'd0;
            r_cnt  <= 3'd0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_enq) begin
            r_q[r_wptr] <= w_cmd;
        end
    end

endmodule

@@ rtl/itp_back.sv @@
// back end: operator stack sequencer and output register
`timescale 1ns / 1ps
module itp_back import itp_pkg::*; #(
    parameter int STACK_DEPTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  t_q_status i_q_status,
    output logic      o_deq,
    output logic      o_out_valid,
    output t_out      o_out_data,
    input  logic      i_out_stall
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CLOSE = 5'b00010,
        S_OP    = 5'b00100,
        S_FLUSH = 5'b01000,
        S_TERM  = 5'b10000
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic            r_ovf, n_ovf;
    logic [7:0]      r_top, n_top;
    t_cmd            r_cur, n_cur;
    logic            r_out_valid;
    t_out            r_out;

    logic            w_can_emit;
    logic            w_emit;
    t_out            w_emit_data;
    logic            w_push;
    logic [7:0]      w_push_val;
    logic            w_pop;
    logic            w_we;
    logic [7:0]      w_second;
    logic [CW-1:0]   w_rd_idx;
    logic            w_has;
    logic            w_top_open;
    t_state          w_done;

    assign w_can_emit = !r_out_valid || !i_out_stall;
    assign w_has      = (r_count != '0);
    assign w_top_open = (r_top == CH_OPEN);
    assign w_done     = r_cur.last ? S_FLUSH : S_IDLE;

    // sequencer: one stack move, one emit per cycle, bar stalls
    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        o_deq       = 1'b0;
        w_emit      = 1'b0;
        w_emit_data = '0;
        w_push      = 1'b0;
        w_push_val  = r_cur.symbol;
        w_pop       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_status.empty) begin
                    unique case (i_cmd.kind)
                        K_OPEN: begin
                            o_deq      = 1'b1;
                            w_push     = 1'b1;
                            w_push_val = i_cmd.symbol;
                            n_state    = i_cmd.last ? S_FLUSH : S_IDLE;
                        end
                        K_CLOSE: begin
                            o_deq   = 1'b1;
                            n_cur   = i_cmd;
                            n_state = S_CLOSE;
                        end
                        K_OP: begin
                            o_deq   = 1'b1;
                            n_cur   = i_cmd;
                            n_state = S_OP;
                        end
                        K_OTHER: begin
                            if (w_can_emit) begin
                                o_deq                  = 1'b1;
                                w_emit                 = 1'b1;
                                w_emit_data.symbol_res = i_cmd.symbol;
                                n_state = i_cmd.last ? S_FLUSH : S_IDLE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_CLOSE: begin
                // pop down to the matching open, which is dropped
                if (!w_has) begin
                    n_state = w_done;
                end else if (w_top_open) begin
                    w_pop   = 1'b1;
                    n_state = w_done;
                end else if (w_can_emit) begin
                    w_emit                 = 1'b1;
                    w_emit_data.symbol_res = r_top;
                    w_pop                  = 1'b1;
                end
            end
            S_OP: begin
                // pop entries of equal or higher weight, then push
                if (w_has && !w_top_open &&
                    (weight_of(r_cur.symbol) <= weight_of(r_top))) begin
                    if (w_can_emit) begin
                        w_emit                 = 1'b1;
                        w_emit_data.symbol_res = r_top;
                        w_pop                  = 1'b1;
                    end
                end else begin
                    w_push  = 1'b1;
                    n_state = w_done;
                end
            end
            S_FLUSH: begin
                if (!w_has) begin
                    n_state = S_TERM;
                end else if (w_can_emit) begin
                    w_emit                 = 1'b1;
                    w_emit_data.symbol_res = r_top;
                    w_pop                  = 1'b1;
                end
            end
            S_TERM: begin
                if (w_can_emit) begin
                    w_emit               = 1'b1;
                    w_emit_data.last_res = 1'b1;
                    w_emit_data.overflow = r_ovf;
                    n_state              = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // stack pointer, cached top entry and sticky overflow
    always_comb begin
        n_count = r_count;
        n_top   = r_top;
        n_ovf   = r_ovf;
        w_we    = 1'b0;
        if (w_push) begin
            if (r_count < CW'(STACK_DEPTH)) begin
                w_we    = 1'b1;
                n_count = r_count + CW'(1);
                n_top   = w_push_val;
            end else begin
                n_ovf = 1'b1;
            end
        end else if (w_pop) begin
            n_count = r_count - CW'(1);
            n_top   = w_second;
        end
        if (r_state == S_TERM && w_emit) begin
            n_ovf = 1'b0;
        end
    end

    // keep the entry below the top prefetched for the next pop
    assign w_rd_idx = n_count - CW'(2);

    itp_ram #(
        .WIDTH (8),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (w_push_val),
        .i_raddr (w_rd_idx[AW-1:0]),
        .o_rdata (w_second)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_top <= n_top;
        r_cur <= n_cur;
        if (w_emit) begin
            r_out <= w_emit_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ rtl/infix_to_postfix_converter.sv @@
// top level of the shunting-yard infix to postfix converter
//
// Input channel: one infix character per item (symbol, last), taken when
// i_in_valid is high and o_in_stall is low. Output channel: postfix
// characters, then one terminator item (symbol_res 0, last_res 1, overflow
// set if a push met a full stack) after the item marked last.
// A four-entry queue sits between the front end and the stack sequencer, so
// input items keep flowing while the sequencer works or the output stalls.
// A plain character passes the queue register, then the output register.
// Sequencer steps: a plain character or '(' is handled straight from idle
// and each emitted stack entry takes its own step; ')' and operators take
// a dispatch step first, then operators a push step and ')' a step that
// drops its '('. The terminator takes an empty-check step, then an emit. Pops
// use a cached top, next entry prefetched, one pop per cycle unless stalled.
// Reset (synchronous, active low) empties the stack, the queue and the
// output register and clears the overflow flag; no clearing pass is needed.
// When the receiver stalls, the output item holds and the next emit waits;
// input is stalled only once the queue is full.
`timescale 1ns / 1ps
module infix_to_postfix_converter import itp_pkg::*; #(
    parameter int STACK_DEPTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_in  i_in_data,
    output logic o_in_stall,
    output logic o_out_valid,
    output t_out o_out_data,
    input  logic i_out_stall
);

    t_cmd      w_cmd;
    t_q_status w_q_status;
    logic      w_deq;

    // accept and classify
    itp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_deq      (w_deq),
        .o_cmd      (w_cmd),
        .o_status   (w_q_status)
    );

    // stack sequencer
    itp_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_q_status  (w_q_status),
        .o_deq       (w_deq),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    // the sequencer never takes from an empty queue
    a_no_deq_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_deq && w_q_status.empty))
        else $error("dequeue from empty queue");

    // a terminator carries a zero character
    a_term_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.last_res) |-> (o_out_data.symbol_res == 8'd0))
        else $error("terminator with nonzero character");

    // overflow is only reported on a terminator
    a_ovf_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.last_res) |-> !o_out_data.overflow)
        else $error("overflow flagged on a character item");

    // a full queue stalls the input until the sequencer takes an entry
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_status.full && !w_deq) |=> o_in_stall)
        else $error("queue full but input not stalled");

endmodule

@@ tb/tb_top.sv @@
// self-checking testbench for the infix to postfix converter
`timescale 1ns / 1ps
module tb_top import itp_pkg::*; ();

    localparam int STACK_DEPTH = 32;
    localparam int RANDOM_ITEMS = 210;

    // typed results for the directed rows
    localparam t_out NO_RES   = '0;
    localparam t_out TERM_OK  = '{symbol_res: 8'h00, last_res: 1'b1, overflow: 1'b0};
    localparam t_out TERM_OVF = '{symbol_res: 8'h00, last_res: 1'b1, overflow: 1'b1};

    // one directed row: symbol, last, repeat count, number of typed results
    typedef struct {
        logic [7:0] sym;
        logic       lst;
        int         reps;
        int         n_typed;
        t_out       r0;
        t_out       r1;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n   = 1'b0;
    logic in_valid  = 1'b0;
    t_in  in_data   = '0;
    logic out_stall = 1'b0;
    logic o_in_stall;
    logic o_out_valid;
    t_out o_out_data;

    // shadow of the operator stack
    logic [7:0] op_stack [STACK_DEPTH];
    int         op_count = 0;
    bit         ovf_seen = 1'b0;

    t_out       step_out [$];
    t_out       postfix_due [$];
    t_in        pending [$];
    t_dir_row   dir_rows [$];
    t_out       want_item;
    int         errors = 0;
    bit         calm_in = 1'b0;
    bit         calm_out = 1'b0;

    infix_to_postfix_converter #(
        .STACK_DEPTH(STACK_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .i_in_data  (in_data),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data),
        .i_out_stall(out_stall)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // operator precedence, zero for anything that is not an operator
    function automatic int op_rank(input logic [7:0] c);
        if (c == CH_MUL || c == CH_DIV) begin
            return 2;
        end else if (c == CH_ADD || c == CH_SUB) begin
            return 1;
        end
        return 0;
    endfunction

    function automatic void due_char(input logic [7:0] c);
        step_out.push_back('{symbol_res: c, last_res: 1'b0, overflow: 1'b0});
    endfunction

    function automatic void stack_push(input logic [7:0] c);
        if (op_count < STACK_DEPTH) begin
            op_stack[op_count] = c;
            op_count++;
        end else begin
            ovf_seen = 1'b1;
        end
    endfunction

    // shunting-yard step: fills step_out with the characters this item releases
    function automatic void shunt_char(input t_in item);
        logic [7:0] c;
        int         w;
        c = item.symbol;
        step_out.delete();
        if (c == CH_OPEN) begin
            stack_push(c);
        end else if (c == CH_CLOSE) begin
            while (op_count > 0 && op_stack[op_count-1] != CH_OPEN) begin
                due_char(op_stack[op_count-1]);
                op_count--;
            end
            if (op_count > 0) begin
                op_count--;
            end
        end else begin
            w = op_rank(c);
            if (w == 0) begin
                due_char(c);
            end else begin
                while (op_count > 0 && op_stack[op_count-1] != CH_OPEN &&
                       w <= op_rank(op_stack[op_count-1])) begin
                    due_char(op_stack[op_count-1]);
                    op_count--;
                end
                stack_push(c);
            end
        end
        // end of expression: flush and terminate
        if (item.last) begin
            while (op_count > 0) begin
                due_char(op_stack[op_count-1]);
                op_count--;
            end
            step_out.push_back('{symbol_res: 8'h00, last_res: 1'b1, overflow: ovf_seen});
            ovf_seen = 1'b0;
        end
    endfunction

    // drive one item after a random gap and wait until it is taken
    task automatic send_item(input t_in item);
        int gap;
        if ($urandom_range(0, 19) == 0) begin
            calm_in = ~calm_in;
        end
        gap = calm_in ? 0 : $urandom_range(0, 7);
        for (int k = 0; k < gap; k++) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
        end
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    function automatic logic [7:0] pick_operand();
        logic [7:0] c;
        case ($urandom_range(0, 3))
            0: c = 8'($urandom_range(8'h30, 8'h39));
            1: begin
                c = 8'($urandom_range(0, 255));
                if (c == CH_OPEN || c == CH_CLOSE || op_rank(c) != 0) begin
                    c = 8'h78;
                end
            end
            default: c = 8'($urandom_range(8'h61, 8'h7a));
        endcase
        return c;
    endfunction

    function automatic logic [7:0] pick_operator();
        case ($urandom_range(0, 3))
            0: return CH_ADD;
            1: return CH_SUB;
            2: return CH_MUL;
            default: return CH_DIV;
        endcase
    endfunction

    // queue one random expression: well formed, deeply nested or noise
    function automatic void gen_expr();
        int mode;
        int depth;
        int terms;
        mode = $urandom_range(0, 9);
        depth = 0;
        if (mode == 0) begin
            // deep nesting, sometimes past the stack depth
            depth = $urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 4);
            for (int k = 0; k < depth; k++) begin
                pending.push_back('{symbol: CH_OPEN, last: 1'b0});
            end
            pending.push_back('{symbol: pick_operand(), last: 1'b0});
            pending.push_back('{symbol: pick_operator(), last: 1'b0});
            pending.push_back('{symbol: pick_operand(), last: 1'b0});
            for (int k = $urandom_range(0, depth); k > 0; k--) begin
                pending.push_back('{symbol: CH_CLOSE, last: 1'b0});
            end
        end else if (mode <= 7) begin
            terms = $urandom_range(1, 8);
            for (int t = 0; t < terms; t++) begin
                while ($urandom_range(0, 3) == 0 && depth < 6) begin
                    pending.push_back('{symbol: CH_OPEN, last: 1'b0});
                    depth++;
                end
                pending.push_back('{symbol: pick_operand(), last: 1'b0});
                while (depth > 0 && $urandom_range(0, 2) == 0) begin
                    pending.push_back('{symbol: CH_CLOSE, last: 1'b0});
                    depth--;
                end
                if (t < terms - 1) begin
                    pending.push_back('{symbol: pick_operator(), last: 1'b0});
                end
            end
            // mostly close what is open, sometimes leave it or overclose
            if ($urandom_range(0, 4) != 0) begin
                depth = depth + $urandom_range(0, 1);
                for (int k = 0; k < depth; k++) begin
                    pending.push_back('{symbol: CH_CLOSE, last: 1'b0});
                end
            end
        end else begin
            // noise: any byte, role characters often, stray last flags
            terms = $urandom_range(1, 10);
            for (int t = 0; t < terms; t++) begin
                if ($urandom_range(0, 1) == 0) begin
                    pending.push_back('{symbol: 8'($urandom_range(0, 255)),
                                        last: ($urandom_range(0, 7) == 0)});
                end else begin
                    pending.push_back('{symbol: ($urandom_range(0, 2) == 0) ? CH_OPEN :
                                                ($urandom_range(0, 1) ? CH_CLOSE :
                                                 pick_operator()),
                                        last: ($urandom_range(0, 7) == 0)});
                end
            end
        end
        pending[pending.size()-1].last = 1'b1;
    endfunction

    // receiver: random stall per result, with calm stretches
    initial begin
        int gap;
        forever begin
            if ($urandom_range(0, 19) == 0) begin
                calm_out = ~calm_out;
            end
            gap = calm_out ? 0 : $urandom_range(0, 7);
            for (int k = 0; k < gap; k++) begin
                @(negedge i_clk);
                out_stall <= 1'b1;
            end
            @(negedge i_clk);
            out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (postfix_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, o_out_data);
                errors++;
            end else begin
                want_item = postfix_due.pop_front();
                if (o_out_data.symbol_res !== want_item.symbol_res) begin
                    $display("%0t: symbol_res expected %h actual %h",
                             $time, want_item.symbol_res, o_out_data.symbol_res);
                    errors++;
                end
                if (o_out_data.last_res !== want_item.last_res) begin
                    $display("%0t: last_res expected %b actual %b",
                             $time, want_item.last_res, o_out_data.last_res);
                    errors++;
                end
                if (o_out_data.overflow !== want_item.overflow) begin
                    $display("%0t: overflow expected %b actual %b",
                             $time, want_item.overflow, o_out_data.overflow);
                    errors++;
                end
            end
        end
    end

    // main sequence
    initial begin
        t_in item;
        int  sent;
        dir_rows = '{
            '{8'h61,    1'b0, 1,  1, '{8'h61, 1'b0, 1'b0}, NO_RES},  // a, right after reset
            '{8'h00,    1'b0, 1,  1, '{8'h00, 1'b0, 1'b0}, NO_RES},  // code zero passes through
            '{8'hFF,    1'b0, 1,  1, '{8'hFF, 1'b0, 1'b0}, NO_RES},
            '{CH_ADD,   1'b0, 1,  0, NO_RES, NO_RES},
            '{8'h62,    1'b0, 1,  0, NO_RES, NO_RES},
            '{CH_MUL,   1'b0, 1,  0, NO_RES, NO_RES},
            '{8'h63,    1'b0, 1,  0, NO_RES, NO_RES},
            '{CH_SUB,   1'b0, 1,  0, NO_RES, NO_RES},               // pops * and +
            '{CH_OPEN,  1'b0, 1,  0, NO_RES, NO_RES},
            '{8'h64,    1'b0, 1,  0, NO_RES, NO_RES},
            '{CH_DIV,   1'b0, 1,  0, NO_RES, NO_RES},
            '{8'h65,    1'b0, 1,  0, NO_RES, NO_RES},
            '{CH_MUL,   1'b0, 1,  0, NO_RES, NO_RES},               // equal weight pops /
            '{8'h66,    1'b0, 1,  0, NO_RES, NO_RES},
            '{CH_CLOSE, 1'b0, 1,  0, NO_RES, NO_RES},
            '{8'h67,    1'b1, 1,  0, NO_RES, NO_RES},
            '{CH_CLOSE, 1'b0, 1,  0, NO_RES, NO_RES},               // close on empty stack
            '{8'h68,    1'b0, 1,  0, NO_RES, NO_RES},
            '{CH_ADD,   1'b0, 1,  0, NO_RES, NO_RES},
            '{CH_CLOSE, 1'b0, 1,  0, NO_RES, NO_RES},               // unmatched close empties
            '{CH_CLOSE, 1'b1, 1,  1, TERM_OK, NO_RES},
            '{CH_OPEN,  1'b0, 2,  0, NO_RES, NO_RES},               // unmatched opens flushed
            '{8'h69,    1'b1, 1,  0, NO_RES, NO_RES},
            '{CH_OPEN,  1'b0, STACK_DEPTH + 2, 0, NO_RES, NO_RES},  // full stack
            '{CH_ADD,   1'b0, 1,  0, NO_RES, NO_RES},
            '{8'h6A,    1'b1, 1,  0, NO_RES, NO_RES},
            '{8'h6B,    1'b1, 1,  2, '{8'h6B, 1'b0, 1'b0}, TERM_OK}, // flag cleared
            '{CH_MUL,   1'b0, 1,  0, NO_RES, NO_RES},
            '{CH_DIV,   1'b1, 1,  0, NO_RES, NO_RES}
        };

        // reset
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows
        foreach (dir_rows[r]) begin
            for (int k = 0; k < dir_rows[r].reps; k++) begin
                item = '{symbol: dir_rows[r].sym, last: dir_rows[r].lst};
                send_item(item);
                shunt_char(item);
                if (dir_rows[r].n_typed == 0) begin
                    foreach (step_out[j]) postfix_due.push_back(step_out[j]);
                end else begin
                    postfix_due.push_back(dir_rows[r].r0);
                    if (dir_rows[r].n_typed > 1) begin
                        postfix_due.push_back(dir_rows[r].r1);
                    end
                end
            end
        end

        // random expressions
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            gen_expr();
            while (pending.size() > 0) begin
                item = pending.pop_front();
                send_item(item);
                shunt_char(item);
                foreach (step_out[j]) postfix_due.push_back(step_out[j]);
                sent++;
            end
        end
        @(negedge i_clk);
        in_valid <= 1'b0;

        // drain
        while (postfix_due.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
        if (postfix_due.size() > 0) begin
            $display("%0t: %0d results never arrived", $time, postfix_due.size());
            errors++;
        end

        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
